[hw/rtl/arp_resolver_table_macros.svh]
// Assertion macros used by the checker file of the ARP resolver.
// No dependencies.
`ifndef ARP_RESOLVER_TABLE_MACROS_SVH
`define ARP_RESOLVER_TABLE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ART_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define ART_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[hw/rtl/art_pkg.sv]
// Shared types and constants of the ARP resolver.
// No dependencies.
`timescale 1ns / 1ps
package art_pkg;
	localparam logic [2:0] CMD_LOAD_ROUTE = 3'd0;
	localparam logic [2:0] CMD_LOAD_IFACE = 3'd1;
	localparam logic [2:0] CMD_LOOKUP     = 3'd2;
	localparam logic [2:0] CMD_RX_ARP     = 3'd3;
	localparam logic [2:0] CMD_REQUEST    = 3'd4;
	localparam logic [2:0] CMD_TICK       = 3'd5;

	localparam logic [15:0] OPC_REQUEST = 16'd1;
	localparam logic [15:0] OPC_REPLY   = 16'd2;

	localparam logic [1:0] ACT_NONE   = 2'd0;
	localparam logic [1:0] ACT_LOOKUP = 2'd1;
	localparam logic [1:0] ACT_PACKET = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_ROUTE_FULL = 2'd1;
	localparam logic [1:0] ST_PEND_FULL  = 2'd2;

	localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	// Controller to datapath commands
	typedef struct packed {
		logic latch;      // capture the command fields
		logic scan_clr;   // reset the route scan
		logic scan_step;  // evaluate one route entry
		logic route_add;  // append entry from latched fields
		logic pend_op;    // perform pending-table operation
		logic finish;     // build and emit the result
	} art_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic scan_done;
	} art_stat_t;

	// Controller states
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_WAIT  = 6'b000100,
		S_EXEC  = 6'b001000,
		S_DONE  = 6'b010000,
		S_SPARE = 6'b100000
	} art_state_t;
endpackage

[hw/rtl/arp_resolver_table.sv]
// Top level of the ARP resolver: controller plus datapath.
// Depends on art_pkg, art_ctrl, art_dp.
//
// channel  direction  transfer
// command  in         start high while busy low
// config   in         timeout_we high (timeout_data)
// result   out        done high for one cycle, cannot be held off
//
// Load, interface, request, tick and unused commands go from idle to the execute
// state, which registers the result. Lookup and received ARP first pass through a
// scan state that reads the route memory once per cycle until every entry is read
// or an exact entry ends the scan. The receiver never stalls.
// Reset clears counts and valid bits at once; no clearing pass.
`timescale 1ns / 1ps
module arp_resolver_table #(
	parameter int ROUTE_ENTRIES = 64,
	parameter int IFACES = 8,
	parameter int PENDING_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        timeout_we,
	input  logic [15:0] timeout_data,
	input  logic [2:0]  cmd,
	input  logic [31:0] ip,
	input  logic [5:0]  prefix_len,
	input  logic [47:0] mac,
	input  logic [2:0]  iface,
	input  logic [15:0] opcode,
	input  logic [31:0] target_ip,
	input  logic [31:0] now_ms,
	output logic        done,
	output logic [1:0]  action,
	output logic        found,
	output logic [47:0] found_mac,
	output logic [1:0]  tx_opcode,
	output logic [2:0]  out_iface,
	output logic [47:0] eth_dest_mac,
	output logic [31:0] sender_ip_out,
	output logic [47:0] sender_mac_out,
	output logic [31:0] target_ip_out,
	output logic [47:0] target_mac_out,
	output logic [1:0]  status
);
	import art_pkg::*;
	art_cmd_t  ctl;
	art_stat_t stat;

	art_ctrl u_ctrl (.clk, .arst_n, .start, .cmd, .stat, .ctl, .busy);

	art_dp #(.ROUTE_ENTRIES(ROUTE_ENTRIES), .IFACES(IFACES),
		.PENDING_ENTRIES(PENDING_ENTRIES)) u_dp (
		.clk, .arst_n, .ctl, .stat, .cfg_we(timeout_we), .cfg_data(timeout_data),
		.cmd, .ip, .prefix_len, .mac, .iface, .opcode, .target_ip, .now_ms,
		.done, .action, .found, .found_mac, .tx_opcode, .out_iface,
		.eth_dest_mac, .sender_ip_out, .sender_mac_out, .target_ip_out,
		.target_mac_out, .status);
endmodule

[hw/rtl/art_ctrl.sv]
// Controller state machine of the ARP resolver.
// Depends on art_pkg.
`timescale 1ns / 1ps
module art_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [2:0]       cmd,
	input  art_pkg::art_stat_t stat,
	output art_pkg::art_cmd_t  ctl,
	output logic             busy
);
	import art_pkg::*;
	art_state_t state_q, state_d;
	logic [2:0] cmd_q;

	// Command latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cmd_q <= CMD_LOAD_ROUTE;
		else if (start && !busy) cmd_q <= cmd;
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		ctl.latch = start && (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (cmd == CMD_LOOKUP || cmd == CMD_RX_ARP) begin
						ctl.scan_clr = 1'b1;
						state_d = S_SCAN;
					end else state_d = S_EXEC;
				end
			end
			S_SCAN: begin
				ctl.scan_step = 1'b1;
				if (stat.scan_done) state_d = S_EXEC;
			end
			S_EXEC: begin
				ctl.route_add = (cmd_q == CMD_LOAD_ROUTE) || (cmd_q == CMD_RX_ARP);
				ctl.pend_op = 1'b1;
				ctl.finish = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);
endmodule

[hw/rtl/art_dp.sv]
// Datapath of the ARP resolver: route memory with serial prefix scan,
// interface table, pending table and result register. Depends on art_pkg.
`timescale 1ns / 1ps
module art_dp #(
	parameter int ROUTE_ENTRIES = 64,
	parameter int IFACES = 8,
	parameter int PENDING_ENTRIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  art_pkg::art_cmd_t ctl,
	output art_pkg::art_stat_t stat,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_data,
	input  logic [2:0]        cmd,
	input  logic [31:0]       ip,
	input  logic [5:0]        prefix_len,
	input  logic [47:0]       mac,
	input  logic [2:0]        iface,
	input  logic [15:0]       opcode,
	input  logic [31:0]       target_ip,
	input  logic [31:0]       now_ms,
	output logic              done,
	output logic [1:0]        action,
	output logic              found,
	output logic [47:0]       found_mac,
	output logic [1:0]        tx_opcode,
	output logic [2:0]        out_iface,
	output logic [47:0]       eth_dest_mac,
	output logic [31:0]       sender_ip_out,
	output logic [47:0]       sender_mac_out,
	output logic [31:0]       target_ip_out,
	output logic [47:0]       target_mac_out,
	output logic [1:0]        status
);
	import art_pkg::*;
	localparam int RW = $clog2(ROUTE_ENTRIES);
	localparam int CW = $clog2(ROUTE_ENTRIES + 1);
	localparam int PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
	localparam int IW = (IFACES > 1) ? $clog2(IFACES) : 1;

	// Latched command fields
	logic [2:0]  cmd_q;
	logic [31:0] ip_q, tip_q, now_q;
	logic [5:0]  plen_q;
	logic [47:0] mac_q;
	logic [2:0]  ifc_q;
	logic [15:0] op_q;
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= cmd; ip_q <= ip; plen_q <= prefix_len; mac_q <= mac;
			ifc_q <= iface; op_q <= opcode; tip_q <= target_ip; now_q <= now_ms;
		end
	end

	// Timeout register
	logic [15:0] timeout_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) timeout_q <= TIMEOUT_RESET;
		else if (cfg_we) timeout_q <= cfg_data;
	end

	// Route memory, one read per cycle
	logic [85:0] route_mem [ROUTE_ENTRIES];
	logic [85:0] rd_s1;
	logic [CW-1:0] count_q, addr_q;
	logic rd_vld_s1, stop_q, hit_q;
	logic [5:0] best_q;
	logic [47:0] bmac_q;
	logic route_full;
	logic to_me, rx_ok;
	logic [5:0] plen_sat;
	assign route_full = (count_q == CW'(ROUTE_ENTRIES));
	assign plen_sat = (plen_q > 6'd32) ? 6'd32 : plen_q;

	always_ff @(posedge clk) begin
		if (ctl.route_add && !route_full && (cmd_q == CMD_LOAD_ROUTE ||
				(rx_ok && !hit_q)))
			route_mem[count_q[RW-1:0]] <= {ip_q,
				(cmd_q == CMD_LOAD_ROUTE) ? plen_sat : 6'd32, mac_q};
		rd_s1 <= route_mem[addr_q[RW-1:0]];
	end

	// Scan: issue address, evaluate the registered entry in the next cycle
	logic [31:0] e_ip, e_mask;
	logic [5:0]  e_p;
	logic issue;
	assign e_ip = rd_s1[85:54];
	assign e_p  = rd_s1[53:48];
	assign e_mask = (e_p == 6'd0) ? 32'd0 :
		(e_p >= 6'd32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF >> e_p);
	assign issue = ctl.scan_step && !stop_q && (addr_q < count_q);
	assign stat.scan_done = ctl.scan_step && !rd_vld_s1 && (stop_q || addr_q >= count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; addr_q <= '0; rd_vld_s1 <= 1'b0; stop_q <= 1'b0;
			hit_q <= 1'b0; best_q <= '0; bmac_q <= '0;
		end else begin
			if (ctl.route_add && !route_full && (cmd_q == CMD_LOAD_ROUTE ||
					(rx_ok && !hit_q)))
				count_q <= count_q + CW'(1);
			if (ctl.scan_clr) begin
				addr_q <= '0; rd_vld_s1 <= 1'b0; stop_q <= 1'b0;
				hit_q <= 1'b0; best_q <= '0; bmac_q <= '0;
			end else begin
				rd_vld_s1 <= issue;
				if (issue) addr_q <= addr_q + CW'(1);
				if (rd_vld_s1 && !stop_q) begin
					if (e_p == 6'd1) begin
						if (e_ip == ip_q) begin
							hit_q <= 1'b1; bmac_q <= rd_s1[47:0]; stop_q <= 1'b1;
						end
					end else if (((ip_q ^ e_ip) & e_mask) == 32'd0 && e_p > best_q) begin
						hit_q <= 1'b1; bmac_q <= rd_s1[47:0]; best_q <= e_p;
					end
				end
			end
		end
	end

	// Interface table
	logic [31:0] if_ip_q  [IFACES];
	logic [47:0] if_mac_q [IFACES];
	logic [IFACES-1:0] if_vld_q;
	logic ifc_ok;
	logic [IW-1:0] ifc_idx;
	assign ifc_ok = 32'(ifc_q) < IFACES;
	assign ifc_idx = IW'(ifc_q);
	always_comb begin
		to_me = 1'b0;
		for (int i = 0; i < IFACES; i++)
			if (if_vld_q[i] && if_ip_q[i] == tip_q) to_me = 1'b1;
	end
	assign rx_ok = to_me && (op_q == OPC_REQUEST || op_q == OPC_REPLY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			if_vld_q <= '0;
			for (int i = 0; i < IFACES; i++) begin
				if_ip_q[i] <= '0; if_mac_q[i] <= '0;
			end
		end else if (ctl.finish && cmd_q == CMD_LOAD_IFACE && ifc_ok) begin
			if_ip_q[ifc_idx] <= ip_q;
			if_mac_q[ifc_idx] <= mac_q;
			if_vld_q[ifc_idx] <= 1'b1;
		end
	end

	// Pending table
	logic [31:0] pd_ip_q   [PENDING_ENTRIES];
	logic [31:0] pd_time_q [PENDING_ENTRIES];
	logic [31:0] pd_age    [PENDING_ENTRIES];
	logic [PENDING_ENTRIES-1:0] pd_vld_q;
	logic [PENDING_ENTRIES-1:0] pd_match, pd_clr_first, pd_expire;
	logic [PENDING_ENTRIES-1:0] pd_free_first;
	logic dup, has_free;
	logic [PW-1:0] free_idx;
	always_comb begin
		dup = 1'b0; has_free = 1'b0; free_idx = '0;
		pd_clr_first = '0; pd_free_first = '0;
		for (int i = 0; i < PENDING_ENTRIES; i++) begin
			pd_match[i] = pd_vld_q[i] && pd_ip_q[i] == ip_q;
			// wrapping age compare: expired once the sign bit clears
			pd_age[i] = now_q - (pd_time_q[i] + {16'd0, timeout_q});
			pd_expire[i] = pd_vld_q[i] && !pd_age[i][31];
		end
		for (int i = PENDING_ENTRIES - 1; i >= 0; i--) begin
			if (pd_match[i]) begin
				dup = 1'b1; pd_clr_first = '0; pd_clr_first[i] = 1'b1;
			end
			if (!pd_vld_q[i]) begin
				has_free = 1'b1; free_idx = PW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pend_op && cmd_q == CMD_REQUEST && !dup && has_free) begin
			pd_ip_q[free_idx] <= ip_q;
			pd_time_q[free_idx] <= now_q;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pd_vld_q <= '0;
		else if (ctl.pend_op) begin
			case (cmd_q)
				CMD_REQUEST: if (!dup && has_free) pd_vld_q[free_idx] <= 1'b1;
				CMD_RX_ARP:  if (rx_ok && op_q == OPC_REPLY)
					pd_vld_q <= pd_vld_q & ~pd_clr_first;
				CMD_TICK:    pd_vld_q <= pd_vld_q & ~pd_expire;
				default: ;
			endcase
		end
	end

	// Result register
	logic [31:0] s_ip;
	logic [47:0] s_mac;
	assign s_ip  = ifc_ok ? if_ip_q[ifc_idx] : 32'd0;
	assign s_mac = ifc_ok ? if_mac_q[ifc_idx] : 48'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= ctl.finish;
	end
	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			action <= ACT_NONE; found <= 1'b0; found_mac <= '0; tx_opcode <= '0;
			out_iface <= '0; eth_dest_mac <= '0; sender_ip_out <= '0;
			sender_mac_out <= '0; target_ip_out <= '0; target_mac_out <= '0;
			status <= ST_OK;
			case (cmd_q)
				CMD_LOAD_ROUTE: if (route_full) status <= ST_ROUTE_FULL;
				CMD_LOOKUP: begin
					action <= ACT_LOOKUP; found <= hit_q; found_mac <= bmac_q;
				end
				CMD_RX_ARP: if (rx_ok) begin
					if (!hit_q && route_full) status <= ST_ROUTE_FULL;
					if (op_q == OPC_REQUEST) begin
						action <= ACT_PACKET; tx_opcode <= OPC_REPLY[1:0];
						out_iface <= ifc_q; eth_dest_mac <= mac_q;
						sender_ip_out <= s_ip; sender_mac_out <= s_mac;
						target_ip_out <= ip_q; target_mac_out <= mac_q;
					end
				end
				CMD_REQUEST: if (!dup) begin
					if (!has_free) status <= ST_PEND_FULL;
					else begin
						action <= ACT_PACKET; tx_opcode <= OPC_REQUEST[1:0];
						out_iface <= ifc_q; eth_dest_mac <= MAC_BCAST;
						sender_ip_out <= s_ip; sender_mac_out <= s_mac;
						target_ip_out <= ip_q;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

[hw/rtl/art_checker.sv]
// Port-level checker for the ARP resolver, bound to the top level.
// Depends on art_pkg and arp_resolver_table_macros.svh.
`timescale 1ns / 1ps
`include "arp_resolver_table_macros.svh"
module art_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] action,
	input logic       found
);
	import art_pkg::*;
	// An accepted command always makes the block busy next cycle
	`ART_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accept without busy")
	// A result ends the command
	`ART_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy, "done while busy")
	// Result strobe lasts one cycle
	`ART_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "done held")
	// found only on lookup answers
	`ART_ASSERT_IMP(a_found_lookup, clk, arst_n, done && found, action == ACT_LOOKUP, "stray found")
endmodule

bind arp_resolver_table art_checker u_chk (.clk, .arst_n, .start, .busy, .done,
	.action, .found);

[verif/testbench.sv]
// Self-checking testbench of the ARP resolver table: directed rows, then random commands.
// Depends on art_pkg and arp_resolver_table.
`timescale 1ns / 1ps
module testbench;
	import art_pkg::*;

	localparam int ROUTES = 64;
	localparam int NIFS = 8;
	localparam int NPEND = 16;
	localparam int CYCLE_LIMIT = 900000;
	localparam int RANDOM_ITEMS = 1550;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] ip;
		logic [5:0]  prefix_len;
		logic [47:0] mac;
		logic [2:0]  iface;
		logic [15:0] opcode;
		logic [31:0] target_ip;
		logic [31:0] now_ms;
	} arp_cmd_t;

	typedef struct packed {
		logic [1:0]  action;
		logic        found;
		logic [47:0] found_mac;
		logic [1:0]  tx_opcode;
		logic [2:0]  out_iface;
		logic [47:0] eth_dest_mac;
		logic [31:0] sender_ip_out;
		logic [47:0] sender_mac_out;
		logic [31:0] target_ip_out;
		logic [47:0] target_mac_out;
		logic [1:0]  status;
	} arp_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic timeout_we = 1'b0;
	logic [15:0] timeout_data = '0;
	logic [2:0] cmd = '0;
	logic [31:0] ip = '0;
	logic [5:0] prefix_len = '0;
	logic [47:0] mac = '0;
	logic [2:0] iface = '0;
	logic [15:0] opcode = '0;
	logic [31:0] target_ip = '0;
	logic [31:0] now_ms = '0;
	logic done;
	arp_res_t got;

	arp_resolver_table u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.timeout_we(timeout_we), .timeout_data(timeout_data),
		.cmd(cmd), .ip(ip), .prefix_len(prefix_len), .mac(mac), .iface(iface),
		.opcode(opcode), .target_ip(target_ip), .now_ms(now_ms),
		.done(done), .action(got.action), .found(got.found), .found_mac(got.found_mac),
		.tx_opcode(got.tx_opcode), .out_iface(got.out_iface),
		.eth_dest_mac(got.eth_dest_mac), .sender_ip_out(got.sender_ip_out),
		.sender_mac_out(got.sender_mac_out), .target_ip_out(got.target_ip_out),
		.target_mac_out(got.target_mac_out), .status(got.status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the block's tables
	logic [31:0] rt_ip [ROUTES];
	logic [5:0]  rt_plen [ROUTES];
	logic [47:0] rt_mac [ROUTES];
	int          rt_count;
	logic [31:0] if_ip [NIFS];
	logic [47:0] if_mac [NIFS];
	logic        if_ok [NIFS];
	logic [31:0] pd_ip [NPEND];
	logic [31:0] pd_time [NPEND];
	logic        pd_ok [NPEND];
	logic [15:0] timeout_val;

	arp_res_t pending_results [$];
	int errors = 0;
	int reports = 0;
	int cycles = 0;
	logic [31:0] ip_pool [24];
	logic [31:0] clock_ms;

	// Longest prefix match; prefix 1 is exact and final, prefix 0 never wins
	function automatic bit lpm(input logic [31:0] dip, output logic [47:0] hit_mac);
		bit hit;
		int best;
		logic [31:0] m;
		hit = 0;
		best = 0;
		hit_mac = '0;
		for (int i = 0; i < rt_count; i++) begin
			if (rt_plen[i] == 6'd1) begin
				if (rt_ip[i] == dip) begin
					hit_mac = rt_mac[i];
					return 1;
				end
			end else begin
				m = (rt_plen[i] == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - rt_plen[i]));
				if ((dip & m) == (rt_ip[i] & m) && rt_plen[i] > best) begin
					hit_mac = rt_mac[i];
					best = rt_plen[i];
					hit = 1;
				end
			end
		end
		return hit;
	endfunction

	function automatic bit route_append(input logic [31:0] a, input logic [5:0] p,
			input logic [47:0] m);
		if (rt_count >= ROUTES)
			return 0;
		rt_ip[rt_count] = a;
		rt_plen[rt_count] = p;
		rt_mac[rt_count] = m;
		rt_count++;
		return 1;
	endfunction

	function automatic void build_packet(inout arp_res_t r, input logic [1:0] op,
			input logic [2:0] ifc, input logic [47:0] dst, input logic [31:0] tip,
			input logic [47:0] tmac);
		r.action = ACT_PACKET;
		r.tx_opcode = op;
		r.out_iface = ifc;
		r.eth_dest_mac = dst;
		r.sender_ip_out = if_ip[ifc];
		r.sender_mac_out = if_mac[ifc];
		r.target_ip_out = tip;
		r.target_mac_out = tmac;
	endfunction

	// Expected result of one command; updates the shadow tables
	function automatic arp_res_t resolve(input arp_cmd_t c);
		arp_res_t r;
		logic [47:0] m;
		bit to_me;
		int slot;
		logic [31:0] d;
		r = '0;
		case (c.cmd)
			CMD_LOAD_ROUTE: begin
				if (!route_append(c.ip, (c.prefix_len > 32) ? 6'd32 : c.prefix_len, c.mac))
					r.status = ST_ROUTE_FULL;
			end
			CMD_LOAD_IFACE: begin
				if_ip[c.iface] = c.ip;
				if_mac[c.iface] = c.mac;
				if_ok[c.iface] = 1'b1;
			end
			CMD_LOOKUP: begin
				r.action = ACT_LOOKUP;
				r.found = lpm(c.ip, m);
				r.found_mac = m;
			end
			CMD_RX_ARP: begin
				to_me = 0;
				for (int i = 0; i < NIFS; i++)
					if (if_ok[i] && if_ip[i] == c.target_ip)
						to_me = 1;
				if (to_me && (c.opcode == OPC_REQUEST || c.opcode == OPC_REPLY)) begin
					if (!lpm(c.ip, m))
						if (!route_append(c.ip, 6'd32, c.mac))
							r.status = ST_ROUTE_FULL;
					if (c.opcode == OPC_REQUEST)
						build_packet(r, OPC_REPLY[1:0], c.iface, c.mac, c.ip, c.mac);
					else begin
						for (int i = 0; i < NPEND; i++)
							if (pd_ok[i] && pd_ip[i] == c.ip) begin
								pd_ok[i] = 1'b0;
								break;
							end
					end
				end
			end
			CMD_REQUEST: begin
				slot = -1;
				for (int i = 0; i < NPEND; i++)
					if (pd_ok[i] && pd_ip[i] == c.ip)
						return r;
				for (int i = NPEND - 1; i >= 0; i--)
					if (!pd_ok[i])
						slot = i;
				if (slot < 0)
					r.status = ST_PEND_FULL;
				else begin
					pd_ok[slot] = 1'b1;
					pd_ip[slot] = c.ip;
					pd_time[slot] = c.now_ms;
					build_packet(r, OPC_REQUEST[1:0], c.iface, MAC_BCAST, c.ip, 48'd0);
				end
			end
			CMD_TICK: begin
				for (int i = 0; i < NPEND; i++)
					if (pd_ok[i]) begin
						d = c.now_ms - (pd_time[i] + {16'd0, timeout_val});
						if (!d[31])
							pd_ok[i] = 1'b0;
					end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Random command, weighted toward addresses that hit the tables
	function automatic arp_cmd_t random_cmd();
		arp_cmd_t c;
		int w;
		c.cmd = CMD_LOOKUP;
		c.ip = ip_pool[$urandom_range(23)];
		c.prefix_len = 6'($urandom_range(63));
		c.mac = 48'({$urandom, $urandom});
		c.iface = 3'($urandom_range(7));
		c.opcode = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2));
		c.target_ip = ($urandom_range(5) == 0) ? $urandom : if_ip[$urandom_range(7)];
		clock_ms += $urandom_range(250);
		if ($urandom_range(99) == 0)
			clock_ms = $urandom;
		c.now_ms = clock_ms;
		if ($urandom_range(7) == 0)
			c.ip = $urandom;
		else if ($urandom_range(2) == 0)
			c.ip[7:0] = 8'($urandom);
		w = $urandom_range(99);
		if (w < 6)
			c.cmd = CMD_LOAD_ROUTE;
		else if (w < 10)
			c.cmd = CMD_LOAD_IFACE;
		else if (w < 35)
			c.cmd = CMD_LOOKUP;
		else if (w < 60)
			c.cmd = CMD_RX_ARP;
		else if (w < 83)
			c.cmd = CMD_REQUEST;
		else if (w < 97)
			c.cmd = CMD_TICK;
		else
			c.cmd = 3'($urandom_range(6, 7));
		if (c.cmd == CMD_LOAD_ROUTE && $urandom_range(1) == 0)
			c.prefix_len = 6'($urandom_range(32));
		return c;
	endfunction

	// One command transfer; the caller lowers start when it idles
	task automatic issue(input arp_cmd_t c, input bit typed, input arp_res_t texp);
		arp_res_t p;
		cmd <= c.cmd;
		ip <= c.ip;
		prefix_len <= c.prefix_len;
		mac <= c.mac;
		iface <= c.iface;
		opcode <= c.opcode;
		target_ip <= c.target_ip;
		now_ms <= c.now_ms;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		p = resolve(c);
		pending_results.push_back(typed ? texp : p);
	endtask

	task automatic idle_gap(input bit allow);
		if (allow && $urandom_range(99) < 29) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Register write, only with nothing in flight
	task automatic write_timeout(input logic [15:0] v);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		timeout_we <= 1'b1;
		timeout_data <= v;
		@(posedge clk);
		timeout_we <= 1'b0;
		timeout_val = v;
	endtask

	// Result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (reports < MAX_REPORTS) begin
					reports++;
					$display("unexpected result %p", got);
				end
			end else if (got !== pending_results[0]) begin
				errors++;
				if (reports < MAX_REPORTS) begin
					reports++;
					$display("mismatch\n  expected %p\n  actual   %p", pending_results[0], got);
				end
				void'(pending_results.pop_front());
			end else
				void'(pending_results.pop_front());
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Directed stimulus table
	arp_cmd_t dir_cmd [$];
	bit dir_typed [$];
	arp_res_t dir_exp [$];

	task automatic add_row(input logic [2:0] k, input logic [31:0] a, input logic [5:0] p,
			input logic [47:0] m, input logic [2:0] f, input logic [15:0] op,
			input logic [31:0] tip, input logic [31:0] t, input bit typed, input arp_res_t e);
		dir_cmd.push_back({k, a, p, m, f, op, tip, t});
		dir_typed.push_back(typed);
		dir_exp.push_back(e);
	endtask

	initial begin
		arp_res_t miss;
		arp_res_t none;
		int n;
		none = '0;
		miss = '0;
		miss.action = ACT_LOOKUP;
		rt_count = 0;
		timeout_val = TIMEOUT_RESET;
		clock_ms = 32'd5000;
		for (int i = 0; i < NIFS; i++) begin
			if_ip[i] = '0;
			if_mac[i] = '0;
			if_ok[i] = 1'b0;
		end
		for (int i = 0; i < NPEND; i++)
			pd_ok[i] = 1'b0;
		for (int i = 0; i < 24; i++)
			ip_pool[i] = $urandom;

		// Empty tables, extremes, each command and each corner case
		add_row(CMD_LOOKUP, 32'h0, 6'd0, '0, 3'd0, 16'd0, '0, '0, 1, miss);
		add_row(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd63, '1, 3'd7, '1, '1, '1, 1, miss);
		add_row(CMD_TICK, '0, 6'd0, '0, 3'd0, 16'd0, '0, '1, 1, none);
		add_row(CMD_LOAD_ROUTE, 32'h0A00_0000, 6'd63, 48'h1111, 3'd0, 16'd0, '0, '0, 1, none);
		add_row(CMD_LOAD_ROUTE, 32'h0A01_0000, 6'd16, 48'h2222, 3'd0, 16'd0, '0, '0, 1, none);
		add_row(CMD_LOAD_ROUTE, 32'h0A01_0203, 6'd1, '1, 3'd0, 16'd0, '0, '0, 1, none);
		add_row(CMD_LOAD_ROUTE, 32'hC0A8_0000, 6'd0, 48'h3333, 3'd0, 16'd0, '0, '0, 1, none);
		add_row(CMD_LOOKUP, 32'h0A01_0203, 6'd0, '0, 3'd0, 16'd0, '0, '0, 0, none);
		add_row(CMD_LOOKUP, 32'h0A01_0909, 6'd0, '0, 3'd0, 16'd0, '0, '0, 0, none);
		add_row(CMD_LOOKUP, 32'hC0A8_0001, 6'd0, '0, 3'd0, 16'd0, '0, '0, 1, miss);
		add_row(CMD_LOAD_IFACE, 32'hC0A8_0101, 6'd0, 48'hAABB_CCDD_EEFF, 3'd0, 16'd0, '0,
			'0, 1, none);
		add_row(CMD_LOAD_IFACE, 32'hFFFF_FFFF, 6'd0, '1, 3'd7, 16'd0, '0, '0, 1, none);
		add_row(CMD_RX_ARP, 32'hC0A8_0105, 6'd0, 48'h0102_0304_0506, 3'd0, OPC_REQUEST,
			32'hC0A8_0101, '0, 0, none);
		add_row(CMD_RX_ARP, 32'hC0A8_0106, 6'd0, 48'h0607, 3'd2, 16'hFFFF, 32'hC0A8_0101,
			'0, 1, none);
		add_row(CMD_RX_ARP, 32'hC0A8_0106, 6'd0, 48'h0607, 3'd0, OPC_REQUEST,
			32'h0101_0101, '0, 1, none);
		add_row(CMD_RX_ARP, 32'hC0A8_0107, 6'd0, 48'h0708, 3'd7, OPC_REQUEST,
			32'hFFFF_FFFF, '0, 0, none);
		add_row(CMD_LOOKUP, 32'hC0A8_0105, 6'd0, '0, 3'd0, 16'd0, '0, '0, 0, none);
		add_row(CMD_REQUEST, 32'hC0A8_0109, 6'd0, '0, 3'd0, 16'd0, '0, 32'd100, 0, none);
		add_row(CMD_REQUEST, 32'hC0A8_0109, 6'd0, '0, 3'd0, 16'd0, '0, 32'd200, 1, none);
		add_row(CMD_RX_ARP, 32'hC0A8_0109, 6'd0, 48'h0909, 3'd0, OPC_REPLY,
			32'hC0A8_0101, '0, 0, none);
		add_row(CMD_REQUEST, 32'hC0A8_010A, 6'd0, '0, 3'd7, 16'd0, '0, 32'hFFFF_FF00, 0, none);
		add_row(CMD_TICK, '0, 6'd0, '0, 3'd0, 16'd0, '0, 32'd999, 1, none);
		add_row(CMD_REQUEST, 32'hC0A8_010A, 6'd0, '0, 3'd7, 16'd0, '0, 32'd1000, 0, none);
		add_row(3'd6, '1, 6'd63, '1, 3'd7, '1, '1, '1, 1, none);
		add_row(3'd7, '0, 6'd0, '0, 3'd0, 16'd0, '0, '0, 1, none);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < dir_cmd.size(); i++) begin
			issue(dir_cmd[i], dir_typed[i], dir_exp[i]);
			idle_gap(1);
		end

		// Random phases across timeout settings, extremes included
		n = 0;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_timeout(16'd1);
				1: write_timeout(16'hFFFF);
				2: write_timeout(16'($urandom_range(1, 65535)));
				default: write_timeout(TIMEOUT_RESET);
			endcase
			for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
				issue(random_cmd(), 0, none);
				idle_gap(n < 600 || n > 900);
				n++;
			end
		end
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/art_pkg.sv
hw/rtl/art_ctrl.sv
hw/rtl/art_dp.sv
hw/rtl/arp_resolver_table.sv
hw/rtl/art_checker.sv
verif/testbench.sv
